### hdl/c_source_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the C source tokenizer
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef C_SOURCE_TOKENIZER_MACROS_SVH
`define C_SOURCE_TOKENIZER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CST_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define CST_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// C source tokenizer package
// Result kinds, separator codes and the fixed separator table with its
// priority matcher.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int LOOKAHEAD_BYTES    = 3;
  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int NUM_SEPS           = 52;

  typedef enum logic [1:0] {
    KIND_WORD    = 2'd0,
    KIND_SEP     = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  localparam logic [5:0] SEP_LINE_OPEN    = 6'd0;
  localparam logic [5:0] SEP_BLOCK_OPEN   = 6'd3;
  localparam logic [5:0] SEP_BLOCK_CLOSE  = 6'd4;
  localparam logic [5:0] SEP_CHAR_QUOTE   = 6'd5;
  localparam logic [5:0] SEP_SPACE        = 6'd44;
  localparam logic [5:0] SEP_NEWLINE      = 6'd49;
  localparam logic [5:0] SEP_TAB          = 6'd50;
  localparam logic [5:0] SEP_STRING_QUOTE = 6'd51;

  // Each entry holds {third, second, first} byte; unused bytes are zero.
  localparam logic [23:0] SEP_BYTES [NUM_SEPS] = '{
    24'h002F2F, 24'h3D3E3E, 24'h3D3C3C, 24'h002A2F, 24'h002F2A, 24'h000027,
    24'h003D2B, 24'h003D2D, 24'h003D2A, 24'h003D2F, 24'h003D3D, 24'h002B2B,
    24'h002D2D, 24'h003D3E, 24'h003D3C, 24'h003D21, 24'h002626, 24'h007C7C,
    24'h005E5E, 24'h003D5E, 24'h003D7C, 24'h003D26, 24'h003D7E, 24'h003E3E,
    24'h003C3C, 24'h00003E, 24'h00003C, 24'h00002B, 24'h00002D, 24'h00002A,
    24'h00002F, 24'h00003D, 24'h000021, 24'h00003F, 24'h000026, 24'h00007C,
    24'h00005E, 24'h00007E, 24'h000028, 24'h000029, 24'h00005B, 24'h00005D,
    24'h00007B, 24'h00007D, 24'h000020, 24'h00002E, 24'h00002C, 24'h00003B,
    24'h00003A, 24'h00000A, 24'h000009, 24'h000022
  };

  localparam logic [1:0] SEP_LEN [NUM_SEPS] = '{
    2'd2, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1
  };

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
    logic [1:0] len;
  } sep_hit_t;

  // First table entry, in table order, that matches the valid window bytes.
  function automatic sep_hit_t sep_find(input logic [7:0] w0, input logic [7:0] w1,
                                        input logic [7:0] w2, input logic [1:0] fill);
    sep_hit_t res;
    logic     ok;
    res = '0;
    for (int k = 0; k < NUM_SEPS; k++) begin
      ok = (SEP_LEN[k] <= fill) && (w0 == SEP_BYTES[k][7:0]) &&
           ((SEP_LEN[k] < 2'd2) || (w1 == SEP_BYTES[k][15:8])) &&
           ((SEP_LEN[k] < 2'd3) || (w2 == SEP_BYTES[k][23:16]));
      if (ok && !res.hit) begin
        res.hit = 1'b1;
        res.idx = 6'(k);
        res.len = SEP_LEN[k];
      end
    end
    return res;
  endfunction

endpackage

### hdl/c_source_tokenizer.sv
// ----------------------------------------------------------------------------
// C source tokenizer
// Splits a byte stream of C source text into word bytes and separator
// tokens over a three-byte lookahead window, and closes each text with a
// summary record carrying the block count.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | in_byte, end_of_input
//  output  | out_valid / out_ready| kind, byte_value, separator_index,
//          |                      | starts_token, quoted_or_comment,
//          |                      | block_count, last_of_run
//
// One source byte is taken per cycle and yields at most one registered result.
// The last byte of a text starts a drain that judges one item at a time, a word
// byte or a whole separator, and then issues the summary record, paced by the
// single window matcher; no byte is taken during the drain.
// Reset is synchronous; there is no clearing pass.
// A stalled output holds its result and stops intake until it is taken.
// ----------------------------------------------------------------------------
module c_source_tokenizer #(
  parameter int COUNT_BITS = cst_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              end_of_input,
  output logic              out_valid,
  input  logic              out_ready,
  output cst_pkg::kind_t    kind,
  output logic [7:0]        byte_value,
  output logic [5:0]        separator_index,
  output logic              starts_token,
  output logic              quoted_or_comment,
  output logic [15:0]       block_count,
  output logic              last_of_run
);
  import cst_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [7:0]            win [LOOKAHEAD_BYTES];
  logic [1:0]            fill;
  logic                  after_sep;
  logic                  in_string_quote;
  logic                  in_char_quote;
  logic                  in_line_comment;
  logic                  in_block_comment;
  logic [COUNT_BITS-1:0] block_counter;
  logic                  draining;

  logic [7:0]            win_next [LOOKAHEAD_BYTES];
  logic [1:0]            fill_next;
  logic                  after_sep_next;
  logic                  in_string_quote_next;
  logic                  in_char_quote_next;
  logic                  in_line_comment_next;
  logic                  in_block_comment_next;
  logic [COUNT_BITS-1:0] block_counter_next;
  logic                  draining_next;

  logic [7:0]            w [LOOKAHEAD_BYTES];
  logic [7:0]            shifted [LOOKAHEAD_BYTES];
  logic [1:0]            wfill;
  logic                  out_free;
  logic                  accept;
  logic                  judge_en;
  logic                  summary_en;
  logic                  emit_word;
  logic                  emit_sep;
  logic                  quoted;
  logic                  white;
  logic [1:0]            drop_len;
  logic [2:0]            src;
  logic [COUNT_BITS-1:0] count_a;
  logic [COUNT_BITS-1:0] total;
  sep_hit_t              hit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !draining && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < LOOKAHEAD_BYTES; i++) begin
      w[i] = (!draining && fill == 2'(i)) ? in_byte : win[i];
    end
  end

  assign wfill      = draining ? fill : fill + 2'd1;
  assign judge_en   = draining ? (out_free && fill != 2'd0)
                               : (accept && !end_of_input && wfill == 2'(LOOKAHEAD_BYTES));
  assign summary_en = draining && out_free && fill == 2'd0;
  assign hit        = sep_find(w[0], w[1], w[2], wfill);
  assign quoted     = in_string_quote || in_char_quote || in_line_comment || in_block_comment;
  assign white      = hit.idx == SEP_SPACE || hit.idx == SEP_TAB || hit.idx == SEP_NEWLINE;
  assign emit_word  = judge_en && !hit.hit;
  assign emit_sep   = judge_en && hit.hit && (quoted || !white);
  assign drop_len   = hit.hit ? hit.len : 2'd1;
  assign count_a    = (judge_en && hit.hit && !after_sep && block_counter < COUNT_MAX)
                      ? block_counter + 1'b1 : block_counter;
  assign total      = (block_counter < COUNT_MAX) ? block_counter + 1'b1 : COUNT_MAX;

  always_comb begin
    src = '0;
    for (int i = 0; i < LOOKAHEAD_BYTES; i++) begin
      src        = 3'(i) + {1'b0, drop_len};
      shifted[i] = (src < 3'(LOOKAHEAD_BYTES)) ? w[src[1:0]] : w[i];
    end
  end

  always_comb begin
    win_next              = win;
    fill_next             = fill;
    after_sep_next        = after_sep;
    in_string_quote_next  = in_string_quote;
    in_char_quote_next    = in_char_quote;
    in_line_comment_next  = in_line_comment;
    in_block_comment_next = in_block_comment;
    block_counter_next    = block_counter;
    draining_next         = draining;
    if (summary_en) begin
      fill_next             = 2'd0;
      after_sep_next        = 1'b1;
      in_string_quote_next  = 1'b0;
      in_char_quote_next    = 1'b0;
      in_line_comment_next  = 1'b0;
      in_block_comment_next = 1'b0;
      block_counter_next    = '0;
      draining_next         = 1'b0;
    end else if (judge_en) begin
      win_next  = shifted;
      fill_next = wfill - drop_len;
      if (hit.hit) begin
        after_sep_next = 1'b1;
        if (hit.idx == SEP_CHAR_QUOTE)   in_char_quote_next    = !in_char_quote;
        if (hit.idx == SEP_STRING_QUOTE) in_string_quote_next  = !in_string_quote;
        if (hit.idx == SEP_LINE_OPEN)    in_line_comment_next  = 1'b1;
        if (hit.idx == SEP_NEWLINE)      in_line_comment_next  = 1'b0;
        if (hit.idx == SEP_BLOCK_OPEN)   in_block_comment_next = 1'b1;
        if (hit.idx == SEP_BLOCK_CLOSE)  in_block_comment_next = 1'b0;
        block_counter_next = (emit_sep && count_a < COUNT_MAX) ? count_a + 1'b1 : count_a;
      end else begin
        after_sep_next = 1'b0;
      end
    end else if (accept) begin
      win_next      = w;
      fill_next     = wfill;
      draining_next = end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill             <= 2'd0;
      after_sep        <= 1'b1;
      in_string_quote  <= 1'b0;
      in_char_quote    <= 1'b0;
      in_line_comment  <= 1'b0;
      in_block_comment <= 1'b0;
      block_counter    <= '0;
      draining         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      fill             <= fill_next;
      after_sep        <= after_sep_next;
      in_string_quote  <= in_string_quote_next;
      in_char_quote    <= in_char_quote_next;
      in_line_comment  <= in_line_comment_next;
      in_block_comment <= in_block_comment_next;
      block_counter    <= block_counter_next;
      draining         <= draining_next;
      if (out_free) begin
        out_valid <= emit_word || emit_sep || summary_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (out_free) begin
      if (summary_en) begin
        kind              <= KIND_SUMMARY;
        byte_value        <= 8'd0;
        separator_index   <= 6'd0;
        starts_token      <= 1'b0;
        quoted_or_comment <= 1'b0;
        block_count       <= 16'(total);
        last_of_run       <= 1'b1;
      end else if (emit_word) begin
        kind              <= KIND_WORD;
        byte_value        <= w[0];
        separator_index   <= 6'd0;
        starts_token      <= after_sep;
        quoted_or_comment <= quoted;
        block_count       <= 16'd0;
        last_of_run       <= !draining;
      end else if (emit_sep) begin
        kind              <= KIND_SEP;
        byte_value        <= 8'd0;
        separator_index   <= hit.idx;
        starts_token      <= 1'b0;
        quoted_or_comment <= quoted;
        block_count       <= 16'd0;
        last_of_run       <= !draining;
      end
    end
  end

endmodule

### hdl/cst_checker.sv
// ----------------------------------------------------------------------------
// C source tokenizer checker
// Port-level properties of the tokenizer, attached by bind.
// ----------------------------------------------------------------------------
`include "c_source_tokenizer_macros.svh"

module cst_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input cst_pkg::kind_t kind,
  input logic [5:0]     separator_index,
  input logic [15:0]    block_count,
  input logic           last_of_run
);
  import cst_pkg::*;

  `CST_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "output valid after reset")
  `CST_ASSERT(a_summary_last, clk, rst, (out_valid && kind == KIND_SUMMARY) |-> last_of_run,
              "summary record not marked last")
  `CST_ASSERT(a_stall_blocks_in, clk, rst, (out_valid && !out_ready) |-> !in_ready,
              "input taken while output stalled")
  `CST_ASSERT(a_word_fields, clk, rst,
              (out_valid && kind == KIND_WORD) |-> (separator_index == 6'd0 && block_count == 16'd0),
              "word byte carries separator or count data")
  `CST_ASSERT(a_out_hold, clk, rst,
              (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(last_of_run)),
              "stalled result changed")

endmodule

bind c_source_tokenizer cst_checker u_cst_checker (.*);
